// ===== hdl/pte_pkg.sv =====
package pte_pkg;

    localparam int TEMPLATE_POINTS = 100;
    localparam int IDX_BITS = 7;
    localparam int FRAC_BITS = 16;
    localparam int QUO_BITS = IDX_BITS + FRAC_BITS;
    localparam int REM_BITS = 29;
    localparam int PROD_A_BITS = 40;
    localparam int CFG_DATA_BITS = 18;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [1:0] REGION_INVALID = 2'd0;
    localparam logic [1:0] REGION_OUTSIDE = 2'd1;
    localparam logic [1:0] REGION_INSIDE = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PEDESTAL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH = 2'd3;

    localparam logic signed [15:0] WIDTH_RESET = 16'sd3891;

    // Window and scale constants held as exact integer ratios.
    localparam logic signed [15:0] D_SCALE = 16'sd16000;
    localparam logic signed [12:0] LO_SCALE = 13'sd3258;
    localparam logic signed [13:0] HI_SCALE = 14'sd5548;
    localparam logic [11:0] A_SCALE = 12'd2839;
    localparam logic [13:0] B_SCALE = 14'd15625;

    localparam logic signed [20:0] LEVEL_MAX = 21'sd262143;
    localparam logic signed [20:0] LEVEL_MIN = -21'sd262144;

    typedef logic signed [16:0] shape_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] region;
    } pte_ctl_t;

    localparam shape_t SHAPE_TAB [TEMPLATE_POINTS] = '{
        -17'sd22, 17'sd64, 17'sd2, -17'sd77, -17'sd56, 17'sd14, 17'sd44,
        17'sd29, 17'sd6, -17'sd4, -17'sd6, -17'sd12, -17'sd24, -17'sd21,
        17'sd48, 17'sd240, 17'sd587, 17'sd1098, 17'sd1792, 17'sd2698, 17'sd3833,
        17'sd5191, 17'sd6764, 17'sd8550, 17'sd10546, 17'sd12733, 17'sd15076,
        17'sd17527, 17'sd20022, 17'sd22469, 17'sd24758, 17'sd26789, 17'sd28522,
        17'sd29982, 17'sd31206, 17'sd32125, 17'sd32623, 17'sd32768, 17'sd32594,
        17'sd32072, 17'sd31218, 17'sd30101, 17'sd28774, 17'sd27272, 17'sd25637,
        17'sd23928, 17'sd22184, 17'sd20414, 17'sd18619, 17'sd16815, 17'sd15026,
        17'sd13289, 17'sd11648, 17'sd10148, 17'sd8821, 17'sd7670, 17'sd6656,
        17'sd5740, 17'sd4928, 17'sd4251, 17'sd3699, 17'sd3219, 17'sd2782,
        17'sd2405, 17'sd2103, 17'sd1864, 17'sd1664, 17'sd1485, 17'sd1322,
        17'sd1172, 17'sd1032, 17'sd899, 17'sd774, 17'sd652, 17'sd535, 17'sd423,
        17'sd316, 17'sd216, 17'sd123, 17'sd39, -17'sd36, -17'sd100, -17'sd152,
        -17'sd192, -17'sd218, -17'sd229, -17'sd227, -17'sd213, -17'sd190,
        -17'sd162, -17'sd130, -17'sd100, -17'sd70, -17'sd45, -17'sd22, -17'sd3,
        17'sd14, 17'sd28, 17'sd41, 17'sd52
    };

    // Positions past the last entry read as zero.
    function automatic shape_t shape_at(input logic [IDX_BITS:0] pos);
        shape_t result;
        if (pos < (IDX_BITS+1)'(TEMPLATE_POINTS))
        begin
            result = SHAPE_TAB[pos[IDX_BITS-1:0]];
        end
        else
        begin
            result = '0;
        end
        return result;
    endfunction

endpackage

// ===== hdl/pte_in_if.sv =====
interface pte_in_if;
    logic        valid;
    logic        ready;
    logic [14:0] sample_time;

    modport source (output valid, output sample_time, input ready);
    modport sink (input valid, input sample_time, output ready);
endinterface

// ===== hdl/pte_out_if.sv =====
interface pte_out_if;
    logic               valid;
    logic               ready;
    logic signed [18:0] level;
    logic [1:0]         region;

    modport source (output valid, output level, output region, input ready);
    modport sink (input valid, input level, input region, output ready);
endinterface

// ===== hdl/pte_front.sv =====
module pte_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [14:0]                         sample_time,
    input  logic signed [16:0]                  pedestal,
    input  logic signed [15:0]                  phase,
    input  logic signed [15:0]                  width,
    output pte_pkg::pte_ctl_t                   ctl,
    output logic [pte_pkg::REM_BITS-1:0]        rem,
    output logic [pte_pkg::QUO_BITS-1:0]        low
);
    import pte_pkg::*;

    logic               v1_reg;
    logic signed [16:0] d_reg;
    logic signed [16:0] d_next;

    logic               v2_reg;
    logic signed [31:0] d16_reg;
    logic signed [31:0] d16_next;
    logic signed [31:0] lo_reg;
    logic signed [31:0] lo_next;
    logic signed [31:0] hi_reg;
    logic signed [31:0] hi_next;

    pte_ctl_t           ctl3_reg;
    pte_ctl_t           ctl3_next;
    logic [28:0]        n_reg;
    logic [31:0]        n_full;

    pte_ctl_t           ctl4_reg;
    logic [PROD_A_BITS-1:0] a_reg;
    logic [PROD_A_BITS-1:0] a_next;

    logic               bad_cfg;
    logic               in_window;

    assign d_next = $signed({2'b00, sample_time}) - $signed({phase[15], phase});
    assign d16_next = 32'(d_reg) * 32'(D_SCALE);
    assign lo_next = 32'(width) * 32'(LO_SCALE);
    assign hi_next = 32'(width) * 32'(HI_SCALE);

    assign bad_cfg = pedestal[16] || phase[15] || width[15] || (width == 16'sd0);
    assign in_window = (d16_reg >= -lo_reg) && (d16_reg <= hi_reg);
    assign n_full = 32'(d16_reg + lo_reg);

    always_comb
    begin
        ctl3_next.valid = v2_reg;
        if (bad_cfg)
        begin
            ctl3_next.region = REGION_INVALID;
        end
        else if (in_window)
        begin
            ctl3_next.region = REGION_INSIDE;
        end
        else
        begin
            ctl3_next.region = REGION_OUTSIDE;
        end
    end

    assign a_next = PROD_A_BITS'(n_reg) * PROD_A_BITS'(A_SCALE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            ctl3_reg <= ctl3_next;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg   <= d_next;
            d16_reg <= d16_next;
            lo_reg  <= lo_next;
            hi_reg  <= hi_next;
            n_reg   <= n_full[28:0];
            a_reg   <= a_next;
        end
    end

    assign ctl = ctl4_reg;
    assign rem = a_reg[PROD_A_BITS-1:PROD_A_BITS-REM_BITS];
    assign low = {a_reg[PROD_A_BITS-REM_BITS-1:0], (QUO_BITS-PROD_A_BITS+REM_BITS)'(0)};

endmodule

// ===== hdl/pte_div.sv =====
module pte_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic signed [15:0]                  width,
    input  pte_pkg::pte_ctl_t                   ctl_in,
    input  logic [pte_pkg::REM_BITS-1:0]        rem_in,
    input  logic [pte_pkg::QUO_BITS-1:0]        low_in,
    output pte_pkg::pte_ctl_t                   ctl_out,
    output logic [pte_pkg::QUO_BITS-1:0]        quo_out
);
    import pte_pkg::*;

    logic [REM_BITS-1:0] b_reg;
    logic [REM_BITS-1:0] b_next;

    pte_ctl_t            ctl_reg [QUO_BITS];
    logic [QUO_BITS-1:0] quo_reg [QUO_BITS];
    logic [REM_BITS-1:0] rem_reg [QUO_BITS-1];
    logic [QUO_BITS-1:0] low_reg [QUO_BITS-1];

    // The divisor is registered from the width register, so it follows a change
    // well before any item reaches the first division stage.
    assign b_next = REM_BITS'(width[14:0]) * REM_BITS'(B_SCALE);

    always_ff @(posedge clk)
    begin
        b_reg <= b_next;
    end

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_stage
        pte_ctl_t            c_in;
        logic [REM_BITS-1:0] r_in;
        logic [QUO_BITS-1:0] l_in;
        logic [QUO_BITS-1:0] q_in;
        logic [REM_BITS:0]   trial;
        logic [REM_BITS+1:0] diff;
        logic                fits;

        if (k == 0)
        begin : g_first
            assign c_in = ctl_in;
            assign r_in = rem_in;
            assign l_in = low_in;
            assign q_in = '0;
        end
        else
        begin : g_next
            assign c_in = ctl_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign l_in = low_reg[k-1];
            assign q_in = quo_reg[k-1];
        end

        assign trial = {r_in, l_in[QUO_BITS-1]};
        assign diff = {1'b0, trial} - {2'b00, b_reg};
        assign fits = !diff[REM_BITS+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[k] <= '0;
            end
            else if (adv)
            begin
                ctl_reg[k] <= c_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                quo_reg[k] <= {q_in[QUO_BITS-2:0], fits};
            end
        end

        if (k < QUO_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= fits ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
                    low_reg[k] <= {l_in[QUO_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign ctl_out = ctl_reg[QUO_BITS-1];
    assign quo_out = quo_reg[QUO_BITS-1];

endmodule

// ===== hdl/pte_interp.sv =====
module pte_interp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  pte_pkg::pte_ctl_t                   ctl_in,
    input  logic [pte_pkg::QUO_BITS-1:0]        quo,
    input  logic signed [17:0]                  height,
    input  logic signed [16:0]                  pedestal,
    output logic                                out_valid,
    output logic signed [18:0]                  level,
    output logic [1:0]                          region
);
    import pte_pkg::*;

    pte_ctl_t               ctl1_reg;
    pte_ctl_t               ctl2_reg;
    pte_ctl_t               ctl3_reg;
    pte_ctl_t               ctl4_reg;
    pte_ctl_t               ctl5_reg;
    pte_ctl_t               ctl6_reg;
    pte_ctl_t               ctl7_reg;

    logic [IDX_BITS:0]      idx_ext;
    shape_t                 lo1_reg;
    shape_t                 hi1_reg;
    logic [FRAC_BITS-1:0]   frac1_reg;

    shape_t                 lo2_reg;
    logic signed [17:0]     diff2_reg;
    logic [FRAC_BITS-1:0]   frac2_reg;

    shape_t                 lo3_reg;
    logic signed [34:0]     p3_reg;
    logic signed [34:0]     p3_next;

    logic signed [35:0]     v_full;
    logic signed [32:0]     v4_reg;

    logic signed [49:0]     prod5_reg;
    logic signed [49:0]     prod5_next;

    logic signed [50:0]     rnd_full;
    logic signed [19:0]     rnd6_reg;

    logic signed [20:0]     sum;
    logic signed [18:0]     level_next;
    logic signed [18:0]     level_reg;

    assign idx_ext = {1'b0, quo[QUO_BITS-1:FRAC_BITS]};
    assign p3_next = 35'(diff2_reg) * 35'($signed({1'b0, frac2_reg}));
    assign v_full = (36'(lo3_reg) <<< FRAC_BITS) + 36'(p3_reg);
    assign prod5_next = 50'(height) * 50'(v4_reg);
    assign rnd_full = 51'(prod5_reg) + (51'sd1 <<< 30);
    assign sum = 21'(pedestal) + 21'(rnd6_reg);

    always_comb
    begin
        case (ctl6_reg.region)
            REGION_INSIDE:
            begin
                if (sum > LEVEL_MAX)
                begin
                    level_next = LEVEL_MAX[18:0];
                end
                else if (sum < LEVEL_MIN)
                begin
                    level_next = LEVEL_MIN[18:0];
                end
                else
                begin
                    level_next = sum[18:0];
                end
            end
            REGION_OUTSIDE:
            begin
                level_next = 19'(pedestal);
            end
            default:
            begin
                level_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
            ctl6_reg <= '0;
            ctl7_reg <= '0;
        end
        else if (adv)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
            ctl6_reg <= ctl5_reg;
            ctl7_reg <= ctl6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lo1_reg   <= shape_at(idx_ext);
            hi1_reg   <= shape_at(idx_ext + (IDX_BITS+1)'(1));
            frac1_reg <= quo[FRAC_BITS-1:0];
            lo2_reg   <= lo1_reg;
            diff2_reg <= 18'(hi1_reg) - 18'(lo1_reg);
            frac2_reg <= frac1_reg;
            lo3_reg   <= lo2_reg;
            p3_reg    <= p3_next;
            v4_reg    <= v_full[32:0];
            prod5_reg <= prod5_next;
            rnd6_reg  <= rnd_full[50:31];
            level_reg <= level_next;
        end
    end

    assign out_valid = ctl7_reg.valid;
    assign level = level_reg;
    assign region = ctl7_reg.region;

endmodule

// ===== hdl/pulse_template_evaluator_core.sv =====
// Throughput: one transfer per cycle while the output register is free; the
// 23-stage restoring divider that maps time to a table position takes one
// quotient bit per stage. Reset clears the stage valid bits and loads the
// configuration registers with their defaults (pulse width 3891, all others
// zero).
module pulse_template_evaluator_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [pte_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [pte_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    pte_in_if.sink                                 samples,
    pte_out_if.source                              results
);
    import pte_pkg::*;

    logic signed [16:0]  pedestal_reg;
    logic signed [17:0]  height_reg;
    logic signed [15:0]  phase_reg;
    logic signed [15:0]  width_reg;

    logic                adv;
    pte_ctl_t            front_ctl;
    logic [REM_BITS-1:0] front_rem;
    logic [QUO_BITS-1:0] front_low;
    pte_ctl_t            div_ctl;
    logic [QUO_BITS-1:0] div_quo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pedestal_reg <= '0;
            height_reg   <= '0;
            phase_reg    <= '0;
            width_reg    <= WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PEDESTAL: pedestal_reg <= cfg_data[16:0];
                CFG_HEIGHT:   height_reg   <= cfg_data[17:0];
                CFG_PHASE:    phase_reg    <= cfg_data[15:0];
                CFG_WIDTH:    width_reg    <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // The whole pipeline moves together whenever the output register is free.
    assign adv = !results.valid || results.ready;
    assign samples.ready = adv;

    pte_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (samples.valid),
        .sample_time (samples.sample_time),
        .pedestal    (pedestal_reg),
        .phase       (phase_reg),
        .width       (width_reg),
        .ctl         (front_ctl),
        .rem         (front_rem),
        .low         (front_low)
    );

    pte_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .width   (width_reg),
        .ctl_in  (front_ctl),
        .rem_in  (front_rem),
        .low_in  (front_low),
        .ctl_out (div_ctl),
        .quo_out (div_quo)
    );

    pte_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .ctl_in    (div_ctl),
        .quo       (div_quo),
        .height    (height_reg),
        .pedestal  (pedestal_reg),
        .out_valid (results.valid),
        .level     (results.level),
        .region    (results.region)
    );

    a_outside_is_pedestal: assert property (
        @(posedge clk) disable iff (!rst_n)
        (results.valid && results.region == REGION_OUTSIDE)
            |-> (results.level == 19'(pedestal_reg))
    ) else $error("outside result differs from pedestal");

    a_invalid_cfg: assert property (
        @(posedge clk) disable iff (!rst_n)
        (results.valid && results.region == REGION_INVALID)
            |-> ((results.level == 19'sd0) && (pedestal_reg[16] || phase_reg[15]
                 || width_reg[15] || width_reg == 16'sd0))
    ) else $error("invalid result without invalid configuration");

    a_zero_height: assert property (
        @(posedge clk) disable iff (!rst_n)
        (results.valid && results.region == REGION_INSIDE && height_reg == 18'sd0)
            |-> (results.level == 19'(pedestal_reg))
    ) else $error("zero height result differs from pedestal");

endmodule
